// File: rtl/core/bf16_to_int8_quantizer_unit_assert.svh
// assertion macros for the bf16 to int8 quantizer
`ifndef BF16_TO_INT8_QUANTIZER_UNIT_ASSERT_SVH
`define BF16_TO_INT8_QUANTIZER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BFQ_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (rst) prop) \
  else $error("bfq assertion failed");
`define BFQ_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("bfq assertion failed");
`else
`define BFQ_ASSERT(lbl, prop)
`define BFQ_ASSERT_RST(lbl, prop)
`endif
`endif

// File: rtl/core/bfq_pkg.sv
// types and constants shared by the quantizer pipeline
`default_nettype none
package bfq_pkg;
  localparam logic [1:0] CLS_NUM  = 2'd0;
  localparam logic [1:0] CLS_ZERO = 2'd1;
  localparam logic [1:0] CLS_SAT  = 2'd2;
  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;

  typedef struct packed {
    logic [1:0]  cls;
    logic        neg;
    logic [31:0] prod;
    logic [8:0]  esum;
    logic        last;
  } mul_t;

  typedef struct packed {
    logic [1:0]  cls;
    logic        neg;
    logic [23:0] sig;
    logic [2:0]  k;
    logic        last;
  } norm_t;

  typedef struct packed {
    logic [7:0] quantized;
    logic       last;
  } res_t;
endpackage
`default_nettype wire

// File: rtl/core/bfq_mul.sv
// stage 1: operand decode and significand multiply
`default_nettype none
module bfq_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] value,
  input  wire logic        last_of_row,
  input  wire logic [31:0] scale,
  output logic             out_valid,
  input  wire logic        out_ready,
  output bfq_pkg::mul_t    out_data
);
  logic vld;
  bfq_pkg::mul_t data_next;
  logic [7:0] ea, eb;
  logic [6:0] ma;
  logic [22:0] mb;
  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  always_comb begin
    ea = value[14:7];
    ma = value[6:0];
    eb = scale[30:23];
    mb = scale[22:0];
    a_nan = (ea == 8'hFF) && (ma != 7'd0);
    b_nan = (eb == 8'hFF) && (mb != 23'd0);
    a_inf = (ea == 8'hFF) && (ma == 7'd0);
    b_inf = (eb == 8'hFF) && (mb == 23'd0);
    a_zero = (ea == 8'd0);
    b_zero = (eb == 8'd0);
    data_next.neg = value[15] ^ scale[31];
    data_next.prod = {25'd1, ma} * {9'd1, mb};
    data_next.esum = {1'b0, ea} + {1'b0, eb};
    data_next.last = last_of_row;
    if (a_nan || b_nan || a_zero || b_zero) begin
      data_next.cls = bfq_pkg::CLS_ZERO;
    end else if (a_inf || b_inf) begin
      data_next.cls = bfq_pkg::CLS_SAT;
    end else begin
      data_next.cls = bfq_pkg::CLS_NUM;
    end
  end

  assign in_ready = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/bfq_norm.sv
// stage 2: round product to single precision and classify exponent
`default_nettype none
module bfq_norm (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bfq_pkg::mul_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bfq_pkg::norm_t     out_data
);
  logic vld;
  bfq_pkg::norm_t data_next;
  logic [23:0] q0;
  logic rb, sticky, rup;
  logic [24:0] qr;
  logic [3:0] sh;
  logic signed [10:0] e, t;

  always_comb begin
    if (in_data.prod[31]) begin
      q0 = in_data.prod[31:8];
      rb = in_data.prod[7];
      sticky = |in_data.prod[6:0];
    end else begin
      q0 = in_data.prod[30:7];
      rb = in_data.prod[6];
      sticky = |in_data.prod[5:0];
    end
    rup = rb && (sticky || q0[0]);
    qr = {1'b0, q0} + {24'd0, rup};
    sh = 4'd7 + {3'd0, in_data.prod[31]} + {3'd0, qr[24]};
    e = signed'({2'b00, in_data.esum}) + signed'({7'd0, sh}) - 11'sd284;
    t = -e - 11'sd17;
    data_next.sig = qr[24] ? qr[24:1] : qr[23:0];
    data_next.neg = in_data.neg;
    data_next.last = in_data.last;
    data_next.k = t[2:0];
    if (in_data.cls != bfq_pkg::CLS_NUM) begin
      data_next.cls = in_data.cls;
    end else if (e >= -11'sd16) begin
      data_next.cls = bfq_pkg::CLS_SAT;
    end else if (e <= -11'sd25) begin
      data_next.cls = bfq_pkg::CLS_ZERO;
    end else begin
      data_next.cls = bfq_pkg::CLS_NUM;
    end
  end

  assign in_ready = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/bfq_int.sv
// stage 3: round to integer half-even and saturate to int8
`default_nettype none
module bfq_int (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bfq_pkg::norm_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output bfq_pkg::res_t       out_data
);
  logic vld;
  bfq_pkg::res_t data_next;
  logic [4:0] sh;
  logic [7:0] x;
  logic [23:0] mask;
  logic sticky, rup;
  logic [7:0] mag;
  logic [7:0] sat;

  always_comb begin
    sh = 5'd16 + {2'd0, in_data.k};
    x = 8'(in_data.sig >> sh);
    mask = (24'd1 << sh) - 24'd1;
    sticky = |(in_data.sig & mask);
    rup = x[0] && (sticky || x[1]);
    mag = {1'b0, x[7:1]} + {7'd0, rup};
    sat = in_data.neg ? 8'h80 : 8'h7F;
    data_next.last = in_data.last;
    if (in_data.cls == bfq_pkg::CLS_ZERO) begin
      data_next.quantized = 8'd0;
    end else if (in_data.cls == bfq_pkg::CLS_SAT || mag[7]) begin
      data_next.quantized = sat;
    end else begin
      data_next.quantized = in_data.neg ? -mag : mag;
    end
  end

  assign in_ready = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/bf16_to_int8_quantizer_unit.sv
// bf16 to int8 quantizer: top level with scale register and three-stage pipeline
// path: each element passes the mul, norm and int stage registers in that order before it reaches m_axis
// throughput: one element per cycle while m_axis_tready is high, each stage holds one item and stalls on its own
// the multiply stage forms an 8x24 significand product
// reset: synchronous; clears all valid bits, scale register returns to 1.0
`default_nettype none
`include "bf16_to_int8_quantizer_unit_assert.svh"
module bf16_to_int8_quantizer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata, // value
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata, // quantized
  output logic             m_axis_tlast
);
  logic [31:0] scale;
  logic v1, r1, v2, r2;
  bfq_pkg::mul_t  d1;
  bfq_pkg::norm_t d2;
  bfq_pkg::res_t  d3;
  logic out_is_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= bfq_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      scale <= cfg_data;
    end
  end

  bfq_mul u_mul (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .value(s_axis_tdata), .last_of_row(s_axis_tlast), .scale(scale),
    .out_valid(v1), .out_ready(r1), .out_data(d1)
  );

  bfq_norm u_norm (
    .clk(clk), .rst(rst),
    .in_valid(v1), .in_ready(r1), .in_data(d1),
    .out_valid(v2), .out_ready(r2), .out_data(d2)
  );

  bfq_int u_int (
    .clk(clk), .rst(rst),
    .in_valid(v2), .in_ready(r2), .in_data(d2),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(d3)
  );

  assign m_axis_tdata = d3.quantized;
  assign m_axis_tlast = d3.last;
  assign out_is_sat = (m_axis_tdata == 8'h7F) || (m_axis_tdata == 8'h80);

  `BFQ_ASSERT(a_cfg_write, cfg_valid |=> scale == $past(cfg_data))
  `BFQ_ASSERT(a_zero_class, (v2 && r2 && d2.cls == bfq_pkg::CLS_ZERO) |=> m_axis_tdata == 8'd0)
  `BFQ_ASSERT(a_sat_class, (v2 && r2 && d2.cls == bfq_pkg::CLS_SAT) |=> out_is_sat)
  `BFQ_ASSERT_RST(a_reset_empty, rst |=> !m_axis_tvalid && !v1 && !v2)
endmodule
`default_nettype wire
